[sv/ccbd_pkg.sv]
package ccbd_pkg;

	// Grid capacity
	localparam int MAX_COLUMNS = 128;
	localparam int MAX_ROWS    = 64;

	localparam int XW     = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
	localparam int YW     = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
	localparam int DEPTH  = MAX_COLUMNS * MAX_ROWS;
	localparam int ADDR_W = $clog2(DEPTH);

	// Wide enough for any register value and any grid dimension
	localparam int DIM_W   = 11;
	localparam int CH_W    = 21;
	localparam int COLOR_W = 8;

	// Configuration port
	localparam int PADDR_W = 3;
	localparam int PDATA_W = 32;
	localparam int REG_SEL = 2;
	localparam logic [7:0] GRID_WIDTH_RST  = 8'd128;
	localparam logic [6:0] GRID_HEIGHT_RST = 7'd64;

	// Heavy box drawing characters and blank
	localparam logic [CH_W-1:0] CH_TL = 21'h0250F;
	localparam logic [CH_W-1:0] CH_TR = 21'h02513;
	localparam logic [CH_W-1:0] CH_BL = 21'h02517;
	localparam logic [CH_W-1:0] CH_BR = 21'h0251B;
	localparam logic [CH_W-1:0] CH_HZ = 21'h02501;
	localparam logic [CH_W-1:0] CH_VT = 21'h02503;
	localparam logic [CH_W-1:0] CH_SP = 21'h00020;

	typedef enum logic [2:0] {
		CMD_PUT   = 3'd0,
		CMD_READ  = 3'd1,
		CMD_COLOR = 3'd2,
		CMD_CLEAR = 3'd3,
		CMD_FILL  = 3'd4,
		CMD_BOX   = 3'd5,
		CMD_TEXT  = 3'd6
	} cmd_t;

	typedef enum logic [1:0] {
		STAT_OK    = 2'd0,
		STAT_RANGE = 2'd1,
		STAT_ORDER = 2'd2
	} status_t;

	typedef enum logic {
		REG_GRID_WIDTH  = 1'b0,
		REG_GRID_HEIGHT = 1'b1
	} reg_t;

	typedef enum logic [1:0] {
		S_INIT,
		S_IDLE,
		S_READ,
		S_WALK
	} state_t;

	typedef struct packed {
		logic [2:0]  cmd;
		logic [6:0]  x_start;
		logic [5:0]  y_start;
		logic [6:0]  x_end;
		logic [5:0]  y_end;
		logic [20:0] char_code;
		logic        color_valid;
		logic [7:0]  color_index;
		logic        blank_inside;
		logic [6:0]  text_index;
		logic [7:0]  text_length;
	} req_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [20:0] read_char;
		logic        read_has_color;
		logic [7:0]  read_color;
	} rsp_t;

	typedef struct packed {
		logic [CH_W-1:0]    ch;
		logic               colored;
		logic [COLOR_W-1:0] color;
	} cell_t;

	typedef struct packed {
		logic              we;
		logic [ADDR_W-1:0] waddr;
		cell_t             wdata;
		logic              re;
		logic [ADDR_W-1:0] raddr;
	} mem_req_t;

	typedef struct packed {
		logic [DIM_W-1:0] cols;
		logic [DIM_W-1:0] rows;
	} grid_dim_t;

	// Linear cell address, row major
	function automatic logic [ADDR_W-1:0] cell_addr(input logic [XW-1:0] x,
		input logic [YW-1:0] y);
		return ADDR_W'(y) * ADDR_W'(MAX_COLUMNS) + ADDR_W'(x);
	endfunction

endpackage

[sv/ccbd_cfg.sv]
module ccbd_cfg (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [ccbd_pkg::PADDR_W-1:0] paddr,
	input  logic [ccbd_pkg::PDATA_W-1:0] pwdata,
	output logic [ccbd_pkg::PDATA_W-1:0] prdata,
	output logic                         pready,
	output ccbd_pkg::grid_dim_t          dim
);

	logic [7:0]     grid_width_q;
	logic [6:0]     grid_height_q;
	logic           wr_en;
	ccbd_pkg::reg_t sel;

	assign pready = 1'b1;
	assign wr_en  = psel & penable & pwrite;
	assign sel    = ccbd_pkg::reg_t'(paddr[ccbd_pkg::REG_SEL]);

	// Register writes in the access phase
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_width_q  <= ccbd_pkg::GRID_WIDTH_RST;
			grid_height_q <= ccbd_pkg::GRID_HEIGHT_RST;
		end else if (wr_en) begin
			unique case (sel)
				ccbd_pkg::REG_GRID_WIDTH:  grid_width_q  <= pwdata[7:0];
				ccbd_pkg::REG_GRID_HEIGHT: grid_height_q <= pwdata[6:0];
				default: ;
			endcase
		end
	end

	// Read back
	always_comb begin
		unique case (sel)
			ccbd_pkg::REG_GRID_WIDTH:  prdata = ccbd_pkg::PDATA_W'(grid_width_q);
			ccbd_pkg::REG_GRID_HEIGHT: prdata = ccbd_pkg::PDATA_W'(grid_height_q);
			default:                   prdata = '0;
		endcase
	end

	// Grid in use is clipped to the store's capacity
	always_comb begin
		dim.cols = (ccbd_pkg::DIM_W'(grid_width_q) > ccbd_pkg::DIM_W'(ccbd_pkg::MAX_COLUMNS)) ?
			ccbd_pkg::DIM_W'(ccbd_pkg::MAX_COLUMNS) : ccbd_pkg::DIM_W'(grid_width_q);
		dim.rows = (ccbd_pkg::DIM_W'(grid_height_q) > ccbd_pkg::DIM_W'(ccbd_pkg::MAX_ROWS)) ?
			ccbd_pkg::DIM_W'(ccbd_pkg::MAX_ROWS) : ccbd_pkg::DIM_W'(grid_height_q);
	end

endmodule

[sv/ccbd_cell_ram.sv]
module ccbd_cell_ram (
	input  logic               clk,
	input  ccbd_pkg::mem_req_t mreq,
	output ccbd_pkg::cell_t    rdata
);

	ccbd_pkg::cell_t mem_q [ccbd_pkg::DEPTH];
	ccbd_pkg::cell_t rdata_q;

	// One write port, one registered read port; read data holds between reads
	always_ff @(posedge clk) begin
		if (mreq.we) begin
			mem_q[mreq.waddr] <= mreq.wdata;
		end
		if (mreq.re) begin
			rdata_q <= mem_q[mreq.raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

[sv/ccbd_seq.sv]
module ccbd_seq (
	input  logic                clk,
	input  logic                arst_n,
	input  ccbd_pkg::grid_dim_t dim,
	input  logic                req_valid,
	output logic                req_ready,
	input  ccbd_pkg::req_t      req,
	output logic                rsp_valid,
	input  logic                rsp_ready,
	output ccbd_pkg::rsp_t      rsp,
	output ccbd_pkg::mem_req_t  mreq,
	input  ccbd_pkg::cell_t     rdata
);

	ccbd_pkg::state_t state_q, state_d;

	logic [ccbd_pkg::ADDR_W-1:0] init_q;
	logic [ccbd_pkg::XW-1:0]     cx_q, x0_q, x1_q;
	logic [ccbd_pkg::YW-1:0]     cy_q, y0_q, y1_q;
	logic                        box_q;
	logic [ccbd_pkg::CH_W-1:0]   ch_q;
	logic                        cv_q;
	logic [ccbd_pkg::COLOR_W-1:0] col_q;
	logic                        blank_q;
	logic                        rd_only_q;
	logic [ccbd_pkg::ADDR_W-1:0] addr_q;
	logic                        rsp_valid_q;
	ccbd_pkg::rsp_t              rsp_q;

	// Widened fields for bound checks
	logic [ccbd_pkg::DIM_W-1:0] xs_dim, ys_dim, xe_dim, ye_dim, tlen_dim, tx_dim;
	logic in_cell, order_bad, rect_out, text_bad;
	logic slot_free, accept;

	// Sequencer controls
	logic walk_start, walk_step, walk_last, walk_wr, rmw_start;
	logic emit;
	ccbd_pkg::rsp_t emit_rsp;
	logic [ccbd_pkg::XW-1:0] wx0, wx1;
	logic [ccbd_pkg::YW-1:0] wy0, wy1;
	logic                    wbox;
	logic [ccbd_pkg::CH_W-1:0] wch;
	logic                    wcv;
	logic [ccbd_pkg::CH_W-1:0] walk_ch;
	logic at_l, at_r, at_t, at_b;

	assign slot_free = !rsp_valid_q || rsp_ready;
	assign req_ready = (state_q == ccbd_pkg::S_IDLE) && slot_free;
	assign accept    = req_valid && req_ready;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// Coordinate checks
	always_comb begin
		xs_dim    = ccbd_pkg::DIM_W'(req.x_start);
		ys_dim    = ccbd_pkg::DIM_W'(req.y_start);
		xe_dim    = ccbd_pkg::DIM_W'(req.x_end);
		ye_dim    = ccbd_pkg::DIM_W'(req.y_end);
		tlen_dim  = ccbd_pkg::DIM_W'(req.text_length);
		tx_dim    = xs_dim + ccbd_pkg::DIM_W'(req.text_index);
		in_cell   = (xs_dim < dim.cols) && (ys_dim < dim.rows);
		order_bad = (req.x_start > req.x_end) || (req.y_start > req.y_end);
		rect_out  = (xe_dim >= dim.cols) || (ye_dim >= dim.rows);
		text_bad  = ((xs_dim + tlen_dim) > dim.cols) || (ys_dim >= dim.rows) ||
			({1'b0, req.text_index} >= req.text_length);
	end

	// Character for the walk position: fill value, or box outline with a blank or kept interior
	always_comb begin
		at_l    = (cx_q == x0_q);
		at_r    = (cx_q == x1_q);
		at_t    = (cy_q == y0_q);
		at_b    = (cy_q == y1_q);
		walk_wr = 1'b1;
		walk_ch = ch_q;
		if (box_q) begin
			if (at_t && at_l)      walk_ch = ccbd_pkg::CH_TL;
			else if (at_t && at_r) walk_ch = ccbd_pkg::CH_TR;
			else if (at_b && at_l) walk_ch = ccbd_pkg::CH_BL;
			else if (at_b && at_r) walk_ch = ccbd_pkg::CH_BR;
			else if (at_t || at_b) walk_ch = ccbd_pkg::CH_HZ;
			else if (at_l || at_r) walk_ch = ccbd_pkg::CH_VT;
			else if (blank_q)      walk_ch = ccbd_pkg::CH_SP;
			else                   walk_wr = 1'b0;
		end
		walk_last = at_r && at_b;
	end

	// Next state, memory access and result
	always_comb begin
		state_d    = state_q;
		mreq       = '0;
		emit       = 1'b0;
		emit_rsp   = '0;
		walk_start = 1'b0;
		walk_step  = 1'b0;
		rmw_start  = 1'b0;
		wx0        = ccbd_pkg::XW'(xs_dim);
		wx1        = ccbd_pkg::XW'(xe_dim);
		wy0        = ccbd_pkg::YW'(ys_dim);
		wy1        = ccbd_pkg::YW'(ye_dim);
		wbox       = 1'b0;
		wch        = req.char_code;
		wcv        = req.color_valid;
		unique case (state_q)
			ccbd_pkg::S_INIT: begin
				mreq.we       = 1'b1;
				mreq.waddr    = init_q;
				mreq.wdata.ch = ccbd_pkg::CH_SP;
				if (init_q == ccbd_pkg::ADDR_W'(ccbd_pkg::DEPTH - 1)) begin
					state_d = ccbd_pkg::S_IDLE;
				end
			end
			ccbd_pkg::S_IDLE: begin
				if (accept) begin
					emit_rsp.status = ccbd_pkg::STAT_OK;
					unique case (ccbd_pkg::cmd_t'(req.cmd)) inside
						ccbd_pkg::CMD_PUT: begin
							emit = 1'b1;
							if (in_cell) begin
								mreq.we       = 1'b1;
								mreq.waddr    = ccbd_pkg::cell_addr(ccbd_pkg::XW'(xs_dim),
									ccbd_pkg::YW'(ys_dim));
								mreq.wdata.ch = req.char_code;
							end else begin
								emit_rsp.status = ccbd_pkg::STAT_RANGE;
							end
						end
						ccbd_pkg::CMD_READ, ccbd_pkg::CMD_COLOR: begin
							if (in_cell) begin
								rmw_start  = 1'b1;
								mreq.re    = 1'b1;
								mreq.raddr = ccbd_pkg::cell_addr(ccbd_pkg::XW'(xs_dim),
									ccbd_pkg::YW'(ys_dim));
								state_d    = ccbd_pkg::S_READ;
							end else begin
								emit            = 1'b1;
								emit_rsp.status = ccbd_pkg::STAT_RANGE;
							end
						end
						ccbd_pkg::CMD_CLEAR: begin
							if ((dim.cols != '0) && (dim.rows != '0)) begin
								walk_start = 1'b1;
								wx0        = '0;
								wy0        = '0;
								wx1        = ccbd_pkg::XW'(dim.cols - 1'b1);
								wy1        = ccbd_pkg::YW'(dim.rows - 1'b1);
								wch        = ccbd_pkg::CH_SP;
								wcv        = 1'b0;
								state_d    = ccbd_pkg::S_WALK;
							end else begin
								emit = 1'b1;
							end
						end
						ccbd_pkg::CMD_FILL, ccbd_pkg::CMD_BOX: begin
							if (order_bad) begin
								emit            = 1'b1;
								emit_rsp.status = ccbd_pkg::STAT_ORDER;
							end else if (rect_out) begin
								emit            = 1'b1;
								emit_rsp.status = ccbd_pkg::STAT_RANGE;
							end else begin
								walk_start = 1'b1;
								wbox       = (ccbd_pkg::cmd_t'(req.cmd) == ccbd_pkg::CMD_BOX);
								state_d    = ccbd_pkg::S_WALK;
							end
						end
						ccbd_pkg::CMD_TEXT: begin
							emit = 1'b1;
							if (text_bad) begin
								emit_rsp.status = ccbd_pkg::STAT_RANGE;
							end else begin
								mreq.we            = 1'b1;
								mreq.waddr         = ccbd_pkg::cell_addr(ccbd_pkg::XW'(tx_dim),
									ccbd_pkg::YW'(ys_dim));
								mreq.wdata.ch      = req.char_code;
								mreq.wdata.colored = req.color_valid;
								mreq.wdata.color   = req.color_valid ? req.color_index : '0;
							end
						end
						default: emit = 1'b1;
					endcase
				end
			end
			ccbd_pkg::S_READ: begin
				// Read data came back; write back the new color or return the cell
				if (slot_free) begin
					emit    = 1'b1;
					state_d = ccbd_pkg::S_IDLE;
					if (rd_only_q) begin
						emit_rsp.read_char      = rdata.ch;
						emit_rsp.read_has_color = rdata.colored;
						emit_rsp.read_color     = rdata.color;
					end else begin
						mreq.we            = 1'b1;
						mreq.waddr         = addr_q;
						mreq.wdata.ch      = rdata.ch;
						mreq.wdata.colored = 1'b1;
						mreq.wdata.color   = col_q;
					end
				end
			end
			ccbd_pkg::S_WALK: begin
				// One cell a cycle; the last cell waits for the result slot
				walk_step = !walk_last || slot_free;
				if (walk_step) begin
					mreq.we            = walk_wr;
					mreq.waddr         = ccbd_pkg::cell_addr(cx_q, cy_q);
					mreq.wdata.ch      = walk_ch;
					mreq.wdata.colored = cv_q;
					mreq.wdata.color   = cv_q ? col_q : '0;
					if (walk_last) begin
						emit    = 1'b1;
						state_d = ccbd_pkg::S_IDLE;
					end
				end
			end
			default: state_d = ccbd_pkg::S_IDLE;
		endcase
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ccbd_pkg::S_INIT;
			init_q      <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ccbd_pkg::S_INIT) begin
				init_q <= init_q + 1'b1;
			end
			if (emit) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// Command context and walk position
	always_ff @(posedge clk) begin
		if (emit) begin
			rsp_q <= emit_rsp;
		end
		if (rmw_start) begin
			addr_q    <= mreq.raddr;
			rd_only_q <= (ccbd_pkg::cmd_t'(req.cmd) == ccbd_pkg::CMD_READ);
			col_q     <= req.color_index;
		end
		if (walk_start) begin
			x0_q    <= wx0;
			x1_q    <= wx1;
			y0_q    <= wy0;
			y1_q    <= wy1;
			cx_q    <= wx0;
			cy_q    <= wy0;
			box_q   <= wbox;
			ch_q    <= wch;
			cv_q    <= wcv;
			col_q   <= req.color_index;
			blank_q <= req.blank_inside;
		end else if (walk_step && !walk_last) begin
			if (at_r) begin
				cx_q <= x0_q;
				cy_q <= cy_q + 1'b1;
			end else begin
				cx_q <= cx_q + 1'b1;
			end
		end
	end

endmodule

[sv/char_cell_box_draw_engine.sv]
// Channel  Direction  Handshake              Payload
// req      in         req_valid / req_ready  ccbd_pkg::req_t (one command)
// rsp      out        rsp_valid / rsp_ready  ccbd_pkg::rsp_t (status, cell read)
// apb      in         psel, penable, pwrite  grid_width at 0x0, grid_height at 0x4
//
// Put char, text char, failed checks and unknown codes finish on accept.
// Read and set color read the cell first; read returns it, set color writes the new color back.
// Fill, box and clear accept the command, then walk the covered cells row by row.
// After reset a clearing pass writes blanks to all MAX_COLUMNS*MAX_ROWS (8192) cells
// with req_ready low; configuration writes are taken meanwhile.
// One result register: a new command is taken while it is empty or being drained.
module char_cell_box_draw_engine (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [ccbd_pkg::PADDR_W-1:0] paddr,
	input  logic [ccbd_pkg::PDATA_W-1:0] pwdata,
	output logic [ccbd_pkg::PDATA_W-1:0] prdata,
	output logic                         pready,
	input  logic                         req_valid,
	output logic                         req_ready,
	input  ccbd_pkg::req_t               req,
	output logic                         rsp_valid,
	input  logic                         rsp_ready,
	output ccbd_pkg::rsp_t               rsp
);

	ccbd_pkg::grid_dim_t dim;
	ccbd_pkg::mem_req_t  mreq;
	ccbd_pkg::cell_t     rdata;

	ccbd_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.dim     (dim)
	);

	ccbd_seq u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.dim       (dim),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp),
		.mreq      (mreq),
		.rdata     (rdata)
	);

	ccbd_cell_ram u_ram (
		.clk   (clk),
		.mreq  (mreq),
		.rdata (rdata)
	);

	// Cell reads are issued only by an accepted command
	a_read_on_accept: assert property (@(posedge clk) disable iff (!arst_n)
		mreq.re |-> (req_valid && req_ready))
		else $error("cell read without accepted item");

	// No read and write of one cell in the same cycle
	a_no_rw_collision: assert property (@(posedge clk) disable iff (!arst_n)
		!(mreq.we && mreq.re && (mreq.waddr == mreq.raddr)))
		else $error("read and write collide on one cell");

	// A command is taken only when its result has room
	a_slot_on_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && req_ready) |-> (!rsp_valid || rsp_ready))
		else $error("item accepted while result slot is full");

	// A read issued on accept holds req_ready low while the read is pending
	a_read_then_idle: assert property (@(posedge clk) disable iff (!arst_n)
		mreq.re |=> !req_ready)
		else $error("new item taken while a cell read is pending");

endmodule

[tb/sv/tb_char_cell_box_draw_engine.sv]
module tb_char_cell_box_draw_engine;
	import ccbd_pkg::*;

	// Code with no command behind it
	localparam logic [2:0] CMD_UNUSED = 3'd7;
	localparam int NUM_PHASES = 10;

	// Grid model plus the queue of replies it predicts
	class grid_scoreboard;
		cell_t cells [DEPTH];
		logic [7:0] width_reg;
		logic [6:0] height_reg;
		rsp_t pending_replies [$];
		int unsigned replies_checked;
		int unsigned mismatches;

		function new();
			foreach (cells[i]) cells[i] = '{ch: CH_SP, colored: 1'b0, color: '0};
			width_reg = GRID_WIDTH_RST;
			height_reg = GRID_HEIGHT_RST;
			replies_checked = 0;
			mismatches = 0;
		endfunction

		function int used_cols();
			return (int'(width_reg) < MAX_COLUMNS) ? int'(width_reg) : MAX_COLUMNS;
		endfunction

		function int used_rows();
			return (int'(height_reg) < MAX_ROWS) ? int'(height_reg) : MAX_ROWS;
		endfunction

		function void set_reg(reg_t r, logic [31:0] value);
			if (r == REG_GRID_WIDTH)
				width_reg = value[7:0];
			else
				height_reg = value[6:0];
		endfunction

		// Plain cells always hold color zero
		function void store(int x, int y, logic [20:0] ch, logic colored, logic [7:0] color);
			cells[y * MAX_COLUMNS + x] = '{ch: ch, colored: colored,
				color: colored ? color : 8'd0};
		endfunction

		function rsp_t predict(req_t r);
			rsp_t o;
			cell_t c;
			int w, h, xs, ys, xe, ye;
			logic [20:0] v;
			bit hit;
			o = '0;
			w = used_cols();
			h = used_rows();
			xs = int'(r.x_start);
			ys = int'(r.y_start);
			xe = int'(r.x_end);
			ye = int'(r.y_end);
			case (r.cmd) inside
				CMD_PUT: begin
					if (xs < w && ys < h) store(xs, ys, r.char_code, 1'b0, 8'd0);
					else o.status = STAT_RANGE;
				end
				CMD_READ: begin
					if (xs < w && ys < h) begin
						c = cells[ys * MAX_COLUMNS + xs];
						o.read_char = c.ch;
						o.read_has_color = c.colored;
						o.read_color = c.color;
					end else begin
						o.status = STAT_RANGE;
					end
				end
				CMD_COLOR: begin
					if (xs < w && ys < h)
						store(xs, ys, cells[ys * MAX_COLUMNS + xs].ch, 1'b1, r.color_index);
					else
						o.status = STAT_RANGE;
				end
				CMD_CLEAR: begin
					for (int i = 0; i < h; i++)
						for (int j = 0; j < w; j++)
							store(j, i, CH_SP, 1'b0, 8'd0);
				end
				CMD_FILL, CMD_BOX: begin
					// order check wins over range check
					if (xs > xe || ys > ye) begin
						o.status = STAT_ORDER;
					end else if (xe >= w || ye >= h) begin
						o.status = STAT_RANGE;
					end else begin
						for (int i = ys; i <= ye; i++) begin
							for (int j = xs; j <= xe; j++) begin
								hit = 1'b1;
								if (r.cmd == CMD_FILL) v = r.char_code;
								else if (i == ys && j == xs) v = CH_TL;
								else if (i == ys && j == xe) v = CH_TR;
								else if (i == ye && j == xs) v = CH_BL;
								else if (i == ye && j == xe) v = CH_BR;
								else if (i == ys || i == ye) v = CH_HZ;
								else if (j == xs || j == xe) v = CH_VT;
								else if (r.blank_inside) v = CH_SP;
								else hit = 1'b0;
								if (hit) store(j, i, v, r.color_valid, r.color_index);
							end
						end
					end
				end
				CMD_TEXT: begin
					if (xs + int'(r.text_length) > w || ys >= h
						|| r.text_index >= r.text_length)
						o.status = STAT_RANGE;
					else
						store(xs + int'(r.text_index), ys, r.char_code, r.color_valid,
							r.color_index);
				end
				default: ;
			endcase
			return o;
		endfunction

		function void note_command(req_t r);
			pending_replies.push_back(predict(r));
		endfunction

		task report_mismatch(string what, logic [31:0] got_val, logic [31:0] want_val);
			mismatches++;
			if (mismatches <= 100)
				$display("reply %0d: %s is %0h, predicted %0h", replies_checked, what,
					got_val, want_val);
		endtask

		task check_reply(rsp_t got);
			rsp_t want;
			if (pending_replies.size() == 0) begin
				report_mismatch("reply with none pending", got, 32'd0);
				return;
			end
			want = pending_replies.pop_front();
			replies_checked++;
			if (got.status !== want.status)
				report_mismatch("status", 32'(got.status), 32'(want.status));
			if (got.read_char !== want.read_char)
				report_mismatch("read_char", 32'(got.read_char), 32'(want.read_char));
			if (got.read_has_color !== want.read_has_color)
				report_mismatch("read_has_color", 32'(got.read_has_color),
					32'(want.read_has_color));
			if (got.read_color !== want.read_color)
				report_mismatch("read_color", 32'(got.read_color), 32'(want.read_color));
		endtask
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [PADDR_W-1:0] paddr = '0;
	logic [PDATA_W-1:0] pwdata = '0;
	logic [PDATA_W-1:0] prdata;
	logic pready;
	logic req_valid = 1'b0;
	logic req_ready;
	req_t req = '0;
	logic rsp_valid;
	logic rsp_ready = 1'b0;
	rsp_t rsp;

	grid_scoreboard sb = new();

	int send_idle_pct = 0;
	int rsp_idle_pct = 0;
	int hold_tag = 0;
	int hold_seen = 0;
	int hold_left = 0;
	int sent_count = 0;
	int kind_count [8];
	int settings_count = 0;

	int phase_cols [NUM_PHASES] = '{255, 1, 0, 9, 16, 128, 2, 0, 127, 5};
	int phase_rows [NUM_PHASES] = '{127, 1, 9, 0, 8, 64, 2, 0, 63, 3};
	int phase_items [NUM_PHASES] = '{200, 120, 50, 50, 220, 250, 150, 220, 200, 190};

	char_cell_box_draw_engine DUT (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req(req),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp(rsp)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Reply side: check each item taken, then pick next ready
	always @(posedge clk) begin
		if (rsp_valid && rsp_ready) sb.check_reply(rsp);
		if (hold_tag != hold_seen) begin
			hold_seen = hold_tag;
			hold_left = 400;
		end
		if (hold_left > 0) begin
			rsp_ready <= 1'b0;
			hold_left--;
		end else begin
			rsp_ready <= ($urandom_range(99) >= rsp_idle_pct);
		end
	end

	function automatic req_t make_cmd(logic [2:0] c, int xs, int ys, int xe, int ye,
		int ch, bit cv, int col, bit blank, int tidx, int tlen);
		req_t r;
		r.cmd = c;
		r.x_start = 7'(xs);
		r.y_start = 6'(ys);
		r.x_end = 7'(xe);
		r.y_end = 6'(ye);
		r.char_code = 21'(ch);
		r.color_valid = cv;
		r.color_index = 8'(col);
		r.blank_inside = blank;
		r.text_index = 7'(tidx);
		r.text_length = 8'(tlen);
		return r;
	endfunction

	// Mostly in-grid commands with random content, the rest raw noise
	function automatic req_t random_cmd(int uw, int uh);
		req_t r;
		logic [95:0] noise;
		int pick, span, tl;
		bit tidy;
		noise = {$urandom, $urandom, $urandom};
		r = noise[$bits(req_t)-1:0];
		pick = $urandom_range(99);
		tidy = ($urandom_range(99) < 85) && uw > 0 && uh > 0;
		if (pick < 18) r.cmd = CMD_PUT;
		else if (pick < 38) r.cmd = CMD_READ;
		else if (pick < 50) r.cmd = CMD_COLOR;
		else if (pick < 66) r.cmd = CMD_TEXT;
		else if (pick < 79) r.cmd = CMD_FILL;
		else if (pick < 92) r.cmd = CMD_BOX;
		else if (pick < 93) r.cmd = CMD_CLEAR;
		else if (pick < 95) r.cmd = CMD_UNUSED;
		if (tidy) begin
			r.x_start = 7'($urandom_range(0, uw - 1));
			r.y_start = 6'($urandom_range(0, uh - 1));
			if (r.cmd == CMD_FILL || r.cmd == CMD_BOX) begin
				// few rectangles reach across the grid
				span = uw - 1 - int'(r.x_start);
				if ($urandom_range(99) >= 3 && span > 7) span = 7;
				r.x_end = r.x_start + 7'($urandom_range(0, span));
				span = uh - 1 - int'(r.y_start);
				if ($urandom_range(99) >= 3 && span > 7) span = 7;
				r.y_end = r.y_start + 6'($urandom_range(0, span));
			end else if (r.cmd == CMD_TEXT) begin
				tl = $urandom_range(1, uw);
				r.text_length = 8'(tl);
				r.x_start = 7'($urandom_range(0, uw - tl));
				r.text_index = 7'($urandom_range(0, tl - 1));
			end
		end
		return r;
	endfunction

	// One item on the command channel
	task push_cmd(input req_t r);
		send_idle_pct = (sent_count < 560) ? 27 : (sent_count < 1120) ? 62 : 0;
		rsp_idle_pct <= (sent_count < 560) ? 62 : (sent_count < 1120) ? 27 : 0;
		while ($urandom_range(99) < send_idle_pct) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req <= r;
		req_valid <= 1'b1;
		@(posedge clk);
		while (!req_ready) @(posedge clk);
		sb.note_command(r);
		sent_count++;
		kind_count[r.cmd]++;
	endtask

	// Stop sending and let every predicted reply come back
	task wait_idle();
		req_valid <= 1'b0;
		while (sb.pending_replies.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task write_reg(input reg_t r, input logic [31:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= PADDR_W'({r, 2'b00});
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		sb.set_reg(r, value);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	initial begin
		int w, h;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed items on the reset grid
		push_cmd(make_cmd(CMD_READ, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
		push_cmd(make_cmd(CMD_PUT, 127, 63, 0, 0, 21'h1FFFFF, 1, 255, 1, 127, 255));
		push_cmd(make_cmd(CMD_READ, 127, 63, 0, 0, 0, 0, 0, 0, 0, 0));
		push_cmd(make_cmd(CMD_COLOR, 127, 63, 0, 0, 0, 0, 8'hAA, 0, 0, 0));
		push_cmd(make_cmd(CMD_READ, 127, 63, 0, 0, 0, 0, 0, 0, 0, 0));
		push_cmd(make_cmd(CMD_FILL, 2, 1, 5, 3, 8'h41, 1, 8'h55, 0, 0, 0));
		push_cmd(make_cmd(CMD_FILL, 5, 0, 2, 3, 8'h41, 1, 8'h55, 0, 0, 0));
		// box over a filled patch: interior kept, then blanked
		push_cmd(make_cmd(CMD_FILL, 10, 10, 14, 13, 8'h78, 0, 0, 0, 0, 0));
		push_cmd(make_cmd(CMD_BOX, 10, 10, 14, 13, 0, 0, 0, 0, 0, 0));
		push_cmd(make_cmd(CMD_READ, 12, 11, 0, 0, 0, 0, 0, 0, 0, 0));
		push_cmd(make_cmd(CMD_BOX, 10, 10, 14, 13, 0, 1, 7, 1, 0, 0));
		push_cmd(make_cmd(CMD_READ, 12, 11, 0, 0, 0, 0, 0, 0, 0, 0));
		// degenerate boxes: one cell, one row, one column
		push_cmd(make_cmd(CMD_BOX, 20, 20, 20, 20, 0, 1, 3, 1, 0, 0));
		push_cmd(make_cmd(CMD_BOX, 30, 5, 33, 5, 0, 0, 0, 0, 0, 0));
		push_cmd(make_cmd(CMD_BOX, 40, 5, 40, 9, 0, 0, 0, 1, 0, 0));
		push_cmd(make_cmd(CMD_READ, 20, 20, 0, 0, 0, 0, 0, 0, 0, 0));
		// text reaching the last column, then bound failures
		push_cmd(make_cmd(CMD_TEXT, 100, 2, 0, 0, 8'h5A, 1, 9, 0, 27, 28));
		push_cmd(make_cmd(CMD_TEXT, 0, 2, 0, 0, 8'h5A, 0, 0, 0, 5, 5));
		push_cmd(make_cmd(CMD_TEXT, 0, 2, 0, 0, 8'h5A, 0, 0, 0, 0, 0));
		push_cmd(make_cmd(CMD_TEXT, 101, 2, 0, 0, 8'h5A, 0, 0, 0, 0, 28));
		push_cmd(make_cmd(CMD_READ, 127, 2, 0, 0, 0, 0, 0, 0, 0, 0));
		push_cmd(make_cmd(CMD_UNUSED, 1, 1, 1, 1, 8'h41, 1, 1, 1, 1, 1));
		push_cmd(make_cmd(CMD_CLEAR, 0, 0, 0, 0, 0, 1, 255, 0, 0, 0));
		push_cmd(make_cmd(CMD_READ, 127, 2, 0, 0, 0, 0, 0, 0, 0, 0));

		// Random items over a series of grid settings
		for (int p = 0; p < NUM_PHASES; p++) begin
			wait_idle();
			w = phase_cols[p];
			h = phase_rows[p];
			if (p == 7) begin
				w = $urandom_range(3, 60);
				h = $urandom_range(3, 40);
			end
			write_reg(REG_GRID_WIDTH, w);
			write_reg(REG_GRID_HEIGHT, h);
			settings_count++;
			for (int n = 0; n < phase_items[p]; n++) begin
				if (p == 5 && n == 60) hold_tag <= hold_tag + 1;
				if (p == 5 && n == 150) wait_idle();
				push_cmd(random_cmd(sb.used_cols(), sb.used_rows()));
			end
		end

		wait_idle();
		repeat (20) @(posedge clk);
		if (sb.pending_replies.size() != 0)
			sb.report_mismatch("replies never seen", 32'(sb.pending_replies.size()), 32'd0);
		$display("ran %0d commands over %0d grid settings: %0d fill, %0d box, %0d clear, %0d text",
			sent_count, settings_count + 1, kind_count[CMD_FILL], kind_count[CMD_BOX],
			kind_count[CMD_CLEAR], kind_count[CMD_TEXT]);
		$display("%0d replies checked, %0d mismatches", sb.replies_checked, sb.mismatches);
		if (sb.mismatches == 0) begin
			$display("char_cell_box_draw_engine: match");
		end else begin
			$display("char_cell_box_draw_engine: mismatch");
		end
		$finish;
	end

	// Watchdog
	initial begin
		#(8 * 3000000);
		$display("char_cell_box_draw_engine: mismatch");
		$finish;
	end

endmodule
